// File: src/spcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spcc_pkg;

    // Defaults for the top level parameters
    localparam int DefFifoDepth = 32;
    localparam int DefPosWidth  = 16;

    // Fixed field widths
    localparam int ArgWidth   = 16;
    localparam int OpWidth    = 2;
    localparam int EntryWidth = OpWidth + ArgWidth;
    localparam int LevelWidth = 6;
    localparam int PosOutWidth = 16;

    // Controller modes, as reported on the result item
    typedef enum logic [1:0] {
        MODE_CAL  = 2'd0,
        MODE_IDLE = 2'd1,
        MODE_MOVE = 2'd2,
        MODE_WAIT = 2'd3
    } mode_t;

    // Command codes held in the queue
    typedef enum logic [1:0] {
        OP_CALIBRATE = 2'd0,
        OP_GOTO      = 2'd1,
        OP_WAIT      = 2'd2,
        OP_SPEED     = 2'd3
    } cmd_op_t;

    // One queued command
    typedef struct packed {
        cmd_op_t             op;
        logic [ArgWidth-1:0] arg;
    } cmd_entry_t;

endpackage

`default_nettype wire

// File: src/stepper_position_command_controller.sv
// Output register: a result item appears in the cycle after its item is accepted.
// Throughput: one item per cycle while results are taken; the mode update and the queue
// push or pop finish in the accept cycle; the memory head is prefetched every cycle.
// Reset (rst_n, async, low): mode calibrating, position and target zero, step period one,
// queue empty, no result pending. The command memory is not cleared; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module stepper_position_command_controller
    import spcc_pkg::*;
#(
    parameter int FIFO_DEPTH = DefFifoDepth,
    parameter int POS_WIDTH  = DefPosWidth
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // detector[0], command_op[2:1], argument[18:3], zero fill
    input  wire logic        s_tuser,   // kind: 0 tick, 1 command push
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // step_left[0], step_right[1], position[17:2],
                                        // mode[19:18], queue_level[25:20],
                                        // command_dropped[26], zero fill
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    // Input fields
    logic                kind;
    logic                detector;
    cmd_op_t             command_op;
    logic [ArgWidth-1:0] argument;

    assign kind       = s_tuser;
    assign detector   = s_tdata[0];
    assign command_op = cmd_op_t'(s_tdata[2:1]);
    assign argument   = s_tdata[18:3];

    // Control state
    mode_t                mode_reg, mode_next;
    logic [POS_WIDTH-1:0] pos_reg, pos_next;
    logic [POS_WIDTH-1:0] target_reg, target_next;
    logic [ArgWidth-1:0]  period_reg, period_next;
    logic [ArgWidth-1:0]  hold_reg, hold_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [AW-1:0]        tail_reg, tail_next;
    logic [CW-1:0]        count_reg, count_next;

    // Result register
    logic                   out_valid_reg;
    logic                   out_left_reg, out_left_next;
    logic                   out_right_reg, out_right_next;
    logic [POS_WIDTH-1:0]   out_pos_reg;
    mode_t                  out_mode_reg;
    logic [CW-1:0]          out_count_reg;
    logic                   out_drop_reg, out_drop_next;

    // Command memory
    cmd_entry_t fifo_mem [FIFO_DEPTH];
    cmd_entry_t rd_data_reg;
    logic       wr_en;
    cmd_entry_t wr_data;

    logic accept;
    logic full;
    logic [ArgWidth-1:0] period_hold;
    logic [POS_WIDTH+ArgWidth-1:0] arg_ext;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CW'(FIFO_DEPTH));
    assign period_hold = (period_reg == '0) ? '0 : period_reg - 1'b1;
    assign arg_ext  = {{POS_WIDTH{1'b0}}, rd_data_reg.arg};
    assign wr_data  = '{op: command_op, arg: argument};

    function automatic logic [AW-1:0] next_index(input logic [AW-1:0] idx);
        next_index = (idx == AW'(FIFO_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    // Mode machine and queue bookkeeping
    always_comb
    begin
        mode_next      = mode_reg;
        pos_next       = pos_reg;
        target_next    = target_reg;
        period_next    = period_reg;
        hold_next      = hold_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        out_left_next  = 1'b0;
        out_right_next = 1'b0;
        out_drop_next  = 1'b0;
        wr_en          = 1'b0;
        if (accept)
        begin
            if (kind)
            begin
                if (full)
                begin
                    out_drop_next = 1'b1;
                end
                else
                begin
                    wr_en      = 1'b1;
                    tail_next  = next_index(tail_reg);
                    count_next = count_reg + 1'b1;
                end
            end
            else
            begin
                case (mode_reg)
                    MODE_CAL:
                    begin
                        if (detector)
                        begin
                            out_right_next = 1'b1;
                        end
                        else
                        begin
                            mode_next   = MODE_IDLE;
                            pos_next    = '0;
                            target_next = '0;
                        end
                    end
                    MODE_IDLE:
                    begin
                        if (hold_reg != '0)
                        begin
                            hold_next = hold_reg - 1'b1;
                        end
                        else if (count_reg != '0)
                        begin
                            // pop the prefetched head entry
                            head_next  = next_index(head_reg);
                            count_next = count_reg - 1'b1;
                            case (rd_data_reg.op)
                                OP_CALIBRATE: mode_next = MODE_CAL;
                                OP_GOTO:
                                begin
                                    target_next = arg_ext[POS_WIDTH-1:0];
                                    mode_next   = MODE_MOVE;
                                end
                                OP_WAIT:
                                begin
                                    hold_next = rd_data_reg.arg;
                                    mode_next = MODE_WAIT;
                                end
                                default: period_next = rd_data_reg.arg;
                            endcase
                        end
                    end
                    MODE_MOVE:
                    begin
                        if (hold_reg != '0)
                        begin
                            hold_next = hold_reg - 1'b1;
                        end
                        else
                        begin
                            if (pos_reg > target_reg)
                            begin
                                out_left_next = 1'b1;
                                pos_next      = pos_reg - 1'b1;
                            end
                            else if (pos_reg < target_reg)
                            begin
                                out_right_next = 1'b1;
                                pos_next       = pos_reg + 1'b1;
                            end
                            else
                            begin
                                mode_next = MODE_IDLE;
                            end
                            hold_next = period_hold;
                        end
                    end
                    default:
                    begin
                        if (hold_reg == '0)
                        begin
                            mode_next = MODE_IDLE;
                        end
                        else
                        begin
                            hold_next = hold_reg - 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_CAL;
            pos_reg       <= '0;
            target_reg    <= '0;
            period_reg    <= ArgWidth'(1);
            hold_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            target_reg <= target_next;
            period_reg <= period_next;
            hold_reg   <= hold_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_left_reg  <= out_left_next;
            out_right_reg <= out_right_next;
            out_pos_reg   <= pos_next;
            out_mode_reg  <= mode_next;
            out_count_reg <= count_next;
            out_drop_reg  <= out_drop_next;
        end
    end

    // Command memory write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fifo_mem[tail_reg] <= wr_data;
        end
    end

    // Head prefetch; a push into the entry being fetched is forwarded
    always_ff @(posedge clk)
    begin
        if (wr_en && (tail_reg == head_next))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= fifo_mem[head_next];
        end
    end

    // Output packing
    logic [PosOutWidth+POS_WIDTH-1:0] pos_ext;
    logic [LevelWidth+CW-1:0]         level_ext;

    assign pos_ext   = {{PosOutWidth{1'b0}}, out_pos_reg};
    assign level_ext = {{LevelWidth{1'b0}}, out_count_reg};
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {5'd0, out_drop_reg, level_ext[LevelWidth-1:0], out_mode_reg,
                        pos_ext[PosOutWidth-1:0], out_right_reg, out_left_reg};

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(FIFO_DEPTH))
        else $error("queue count above depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty queue with head and tail apart");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_drop_reg) |-> full)
        else $error("dropped command while queue not full");

    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_left_reg && out_right_reg))
        else $error("left and right step in one item");

endmodule

`default_nettype wire
